// ===== rtl/core/psc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for pressure sensor compensation
// Holds register indexes, the unpacked coefficient set and the fixed
// constants of the first-order compensation formulas.
// ----------------------------------------------------------------------------
package psc_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_CAL_ONE   = 3'd0,
		REG_CAL_TWO   = 3'd1,
		REG_CAL_THREE = 3'd2,
		REG_CAL_FOUR  = 3'd3,
		REG_SURFACE   = 3'd4
	} cfg_reg_t;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int RAW_W       = 16;
	localparam int TEMP_W      = 14;
	localparam int PRESS_W     = 19;
	localparam int DEPTH_W     = 25;
	localparam int SURFACE_W   = 15;

	// Formula constants.
	localparam logic [17:0]        UT1_BASE     = 18'd20224;
	localparam logic [6:0]         C6_BIAS      = 7'd50;
	localparam logic signed [10:0] C4_BIAS      = 11'sd512;
	localparam logic signed [19:0] SENS_BASE    = 20'sd24576;
	localparam logic signed [17:0] D1_BIAS      = 18'sd7168;
	localparam logic signed [13:0] TEMP_BASE    = 14'sd200;
	localparam logic signed [23:0] PRESS_BASE   = 24'sd2500;
	localparam logic signed [23:0] PRESS_MAX    = 24'sd200000;
	localparam logic signed [23:0] PRESS_MIN    = -24'sd200000;
	localparam logic signed [26:0] DEPTH_SCALE  = 27'sd102;
	localparam logic signed [26:0] DEPTH_MAX    = 27'sd25000000;
	localparam logic [14:0]        SURFACE_RST  = 15'd10090;

	// Coefficients unpacked from the calibration words, plus surface level.
	typedef struct packed {
		logic [14:0] c1;
		logic [11:0] c2;
		logic [9:0]  c3;
		logic [9:0]  c4;
		logic [10:0] c5;
		logic [5:0]  c6;
		logic [14:0] surface;
	} coef_t;

endpackage

// ===== rtl/core/psc_coef.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_coef: calibration register file and coefficient unpacking
// Holds the four calibration words and the surface pressure, and splits the
// words into the six compensation coefficients.
// ----------------------------------------------------------------------------
module psc_coef (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [psc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]   wr_data,
	output psc_pkg::coef_t                   coef
);
	import psc_pkg::*;

	logic [15:0] cal_one_q;
	logic [15:0] cal_two_q;
	logic [15:0] cal_three_q;
	logic [15:0] cal_four_q;
	logic [14:0] surface_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_one_q   <= '0;
			cal_two_q   <= '0;
			cal_three_q <= '0;
			cal_four_q  <= '0;
			surface_q   <= SURFACE_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_CAL_ONE:   cal_one_q   <= wr_data;
				REG_CAL_TWO:   cal_two_q   <= wr_data;
				REG_CAL_THREE: cal_three_q <= wr_data;
				REG_CAL_FOUR:  cal_four_q  <= wr_data;
				REG_SURFACE:   surface_q   <= wr_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Coefficient bit layout of the calibration PROM.
	always_comb begin
		coef.c1      = cal_one_q[15:1];
		coef.c2      = {cal_three_q[5:0], cal_four_q[5:0]};
		coef.c3      = cal_four_q[15:6];
		coef.c4      = cal_three_q[15:6];
		coef.c5      = {cal_one_q[0], cal_two_q[15:6]};
		coef.c6      = cal_two_q[5:0];
		coef.surface = surface_q;
	end

endmodule

// ===== rtl/core/psc_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pipe: six-stage compensation datapath
// Stage 1 forms dT and D1 offset, stage 2 the three dT products, stage 3
// temperature, OFF and SENS, stage 4 the SENS product, stage 5 pressure with
// saturation, stage 6 depth with clamping.
// ----------------------------------------------------------------------------
module psc_pipe (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [psc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [psc_pkg::RAW_W-1:0]           raw_temperature,
	input  psc_pkg::coef_t                      coef,
	output logic                                out_valid,
	output logic signed [psc_pkg::TEMP_W-1:0]   temp_tenths,
	output logic signed [psc_pkg::PRESS_W-1:0]  press_tenths,
	output logic [psc_pkg::DEPTH_W-1:0]         depth_thousandths
);
	import psc_pkg::*;

	// Valid bits that travel with the data.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [17:0] dt_s1, d1m_s1;
	logic signed [25:0] t_prod_s2;
	logic signed [28:0] o_prod_s2, s_prod_s2;
	logic signed [17:0] d1m_s2;
	logic signed [13:0] temp_s3;
	logic signed [17:0] off_s3, d1m_s3;
	logic signed [19:0] sens_s3;
	logic signed [13:0] temp_s4;
	logic signed [17:0] off_s4;
	logic signed [37:0] x_prod_s4;
	logic signed [13:0] temp_s5;
	logic signed [18:0] press_s5;
	logic signed [13:0] temp_s6;
	logic signed [18:0] press_s6;
	logic [24:0]        depth_s6;

	logic [17:0]        ut1;
	logic signed [17:0] dt_d, d1m_d;
	logic [6:0]         c6b;
	logic signed [10:0] c4m;
	logic signed [17:0] off_d;
	logic signed [19:0] sens_d;
	logic signed [13:0] temp_d;
	logic signed [23:0] x_d;
	logic signed [27:0] x10_d;
	logic signed [23:0] p_full_d;
	logic signed [18:0] press_d;
	logic signed [19:0] diff_d;
	logic signed [26:0] depth_prod_d;
	logic [24:0]        depth_d;

	// Valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: temperature difference and offset raw pressure.
	assign ut1   = {4'b0000, coef.c5, 3'b000} + UT1_BASE;
	assign dt_d  = $signed({2'b00, raw_temperature}) - $signed(ut1);
	assign d1m_d = $signed({2'b00, raw_pressure}) - D1_BIAS;

	always_ff @(posedge clk) begin
		dt_s1  <= dt_d;
		d1m_s1 <= d1m_d;
	end

	// Stage 2: the three products on dT.
	assign c6b = {1'b0, coef.c6} + C6_BIAS;
	assign c4m = $signed({1'b0, coef.c4}) - C4_BIAS;

	always_ff @(posedge clk) begin
		t_prod_s2 <= dt_s1 * $signed({1'b0, c6b});
		o_prod_s2 <= dt_s1 * c4m;
		s_prod_s2 <= dt_s1 * $signed({1'b0, coef.c3});
		d1m_s2    <= d1m_s1;
	end

	// Stage 3: temperature, offset and sensitivity.
	assign temp_d = 14'(t_prod_s2 >>> 10) + TEMP_BASE;
	assign off_d  = $signed({4'b0000, coef.c2, 2'b00}) + 18'(o_prod_s2 >>> 12);
	assign sens_d = $signed({5'b00000, coef.c1}) + 20'(s_prod_s2 >>> 10) + SENS_BASE;

	always_ff @(posedge clk) begin
		temp_s3 <= temp_d;
		off_s3  <= off_d;
		sens_s3 <= sens_d;
		d1m_s3  <= d1m_s2;
	end

	// Stage 4: sensitivity times offset raw pressure.
	always_ff @(posedge clk) begin
		temp_s4   <= temp_s3;
		off_s4    <= off_s3;
		x_prod_s4 <= sens_s3 * d1m_s3;
	end

	// Stage 5: pressure in 0.1 mbar, saturated to range.
	assign x_d      = 24'(x_prod_s4 >>> 14) - off_s4;
	assign x10_d    = (28'(x_d) <<< 3) + (28'(x_d) <<< 1);
	assign p_full_d = 24'(x10_d >>> 5) + PRESS_BASE;

	always_comb begin
		if (p_full_d > PRESS_MAX) begin
			press_d = 19'(PRESS_MAX);
		end else if (p_full_d < PRESS_MIN) begin
			press_d = 19'(PRESS_MIN);
		end else begin
			press_d = 19'(p_full_d);
		end
	end

	always_ff @(posedge clk) begin
		temp_s5  <= temp_s4;
		press_s5 <= press_d;
	end

	// Stage 6: depth below the surface level, zero above it.
	assign diff_d       = 20'(press_s5) - $signed({5'b00000, coef.surface});
	assign depth_prod_d = 27'(diff_d) * DEPTH_SCALE;

	always_comb begin
		if (diff_d <= 20'sd0) begin
			depth_d = '0;
		end else if (depth_prod_d > DEPTH_MAX) begin
			depth_d = 25'(DEPTH_MAX);
		end else begin
			depth_d = 25'(depth_prod_d);
		end
	end

	always_ff @(posedge clk) begin
		temp_s6  <= temp_s5;
		press_s6 <= press_s5;
		depth_s6 <= depth_d;
	end

	assign out_valid         = v_s6;
	assign temp_tenths       = temp_s6;
	assign press_tenths      = press_s6;
	assign depth_thousandths = depth_s6;

endmodule

// ===== rtl/core/pressure_sensor_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation: first-order pressure/temperature compensation
// Turns a raw pressure and temperature conversion pair into compensated
// temperature, pressure and depth using coefficients from calibration words.
//
//   Channel   Handshake              Payload
//   -------   --------------------   --------------------------------------
//   request   start, busy            raw_pressure, raw_temperature
//   result    done (strobe)          temp_tenths, press_tenths,
//                                    depth_thousandths
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A request is taken every cycle; busy is always low. Each result appears
// for one cycle with done high, after passing through the six register
// stages, two of them holding the multiplier products.
// Reset clears the stage valid bits and loads the register defaults; results
// cannot be held off, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [psc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [psc_pkg::RAW_W-1:0]           raw_temperature,
	output logic                                done,
	output logic signed [psc_pkg::TEMP_W-1:0]   temp_tenths,
	output logic signed [psc_pkg::PRESS_W-1:0]  press_tenths,
	output logic [psc_pkg::DEPTH_W-1:0]         depth_thousandths,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import psc_pkg::*;

	coef_t coef;

	// The pipeline and register file never back-pressure.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Calibration registers.
	psc_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	// Compensation datapath.
	psc_pipe u_pipe (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (start && !busy),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.coef              (coef),
		.out_valid         (done),
		.temp_tenths       (temp_tenths),
		.press_tenths      (press_tenths),
		.depth_thousandths (depth_thousandths)
	);

endmodule

// ===== rtl/core/psc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for pressure sensor compensation
// Watches latency, result ranges and the depth/pressure relation.
// ----------------------------------------------------------------------------
module psc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                done,
	input  logic signed [psc_pkg::PRESS_W-1:0]  press_tenths,
	input  logic [psc_pkg::DEPTH_W-1:0]         depth_thousandths
);
	import psc_pkg::*;

	// Every accepted request yields a result with done high.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("result missing six cycles after request");

	// No result appears without a matching earlier request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##6 !done)
		else $error("result without a request");

	// Pressure stays inside its saturation window.
	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (press_tenths <= 19'sd200000) && (press_tenths >= -19'sd200000))
		else $error("pressure outside saturation range");

	// Depth is clamped, and a positive depth needs a positive pressure.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (depth_thousandths <= 25'd25000000)
			&& ((depth_thousandths == '0) || (press_tenths > 19'sd0)))
		else $error("depth out of range or inconsistent with pressure");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (.*);
